/* rtl/team_grouped_queue_defines.svh */
// ----------------------------------------------------------------------------
// team_grouped_queue_defines
// Assertion macros shared by the team queue RTL.
// ----------------------------------------------------------------------------
`ifndef TEAM_GROUPED_QUEUE_DEFINES_SVH
`define TEAM_GROUPED_QUEUE_DEFINES_SVH

// condition holds on every clock edge out of reset
`define TGQ_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define TGQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/tgq_pkg.sv */
// ----------------------------------------------------------------------------
// tgq_pkg
// Types and codes of the team queue.
// ----------------------------------------------------------------------------
package tgq_pkg;

    localparam logic [1:0] K_ASSIGN  = 2'd0;
    localparam logic [1:0] K_ENQUEUE = 2'd1;
    localparam logic [1:0] K_DEQUEUE = 2'd2;
    localparam logic [1:0] K_CLEAR   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DEQ   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_E1   = 8'b0000_0010,
        S_E2   = 8'b0000_0100,
        S_D1   = 8'b0000_1000,
        S_D2   = 8'b0001_0000,
        S_D3   = 8'b0010_0000,
        S_CLR  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

endpackage

/* rtl/team_grouped_queue.sv */
// ----------------------------------------------------------------------------
// team_grouped_queue
// Grouped FIFO: elements queue per team, teams are served in arrival order.
// ----------------------------------------------------------------------------
// One item at a time, one result beat per item. Assign goes straight to the
// result state, enqueue steps through E1 and E2 (E1 alone when the pool is
// full), dequeue through D1, D2 and D3 (none when empty). The result state
// waits while output backpressure holds the previous beat, and each step
// waits for a registered RAM read (map, team pointers, pool links). Reset and
// every clear item run a clearing pass over the map and team tables during
// which no item is accepted; the clear item's result follows the pass.
`include "team_grouped_queue_defines.svh"

module team_grouped_queue #(
    parameter int TEAMS       = 256,
    parameter int ELEMENT_IDS = 4096,
    parameter int POOL_SIZE   = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // element[11:0], team[19:12], zero pad
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // element_out[11:0], zero pad
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    localparam int TW   = $clog2(TEAMS);
    localparam int EW   = $clog2(ELEMENT_IDS);
    localparam int PW   = $clog2(POOL_SIZE);
    localparam int XW   = (EW > 12) ? EW : 12;
    localparam int CLRN = (ELEMENT_IDS > TEAMS) ? ELEMENT_IDS : TEAMS;
    localparam int CW   = $clog2(CLRN + 1);
    localparam int OCW  = $clog2(TEAMS + 1);
    localparam int TMW  = 1 + 2 * PW;

    tgq_pkg::t_state r_state, n_state;

    logic [11:0]     r_elem;
    logic            r_rng;
    logic [TW-1:0]   r_t;
    logic [PW-1:0]   r_slot;
    logic [CW-1:0]   r_clr;
    logic            r_reply;
    logic [TW-1:0]   r_oh, r_ot;
    logic [OCW-1:0]  r_ocnt;
    logic [PW:0]     r_free_cnt, r_fresh;
    logic [1:0]      r_res_st;
    logic [11:0]     r_res_eout;
    logic            r_out_valid;
    logic [1:0]      r_status;
    logic [11:0]     r_eout;

    logic [11:0]     in_elem;
    logic [7:0]      in_team;
    logic [XW-1:0]   in_elem_x;
    logic            accept;

    assign in_elem   = s_axis_tdata[11:0];
    assign in_team   = s_axis_tdata[19:12];
    assign in_elem_x = XW'(in_elem);
    assign s_axis_tready = (r_state == tgq_pkg::S_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;

    // memories
    logic            map_we, map_re;
    logic [EW-1:0]   map_waddr;
    logic [TW-1:0]   map_wdata, map_rd;
    logic            ord_we, ord_re;
    logic [TW-1:0]   ord_rd;
    logic            tm_we, tm_re;
    logic [TW-1:0]   tm_waddr, tm_raddr;
    logic [TMW-1:0]  tm_wdata, tm_rd;
    logic            pe_we, pool_re;
    logic [11:0]     pe_rd;
    logic            pn_we;
    logic [PW-1:0]   pn_rd;
    logic            fs_we, fs_re;
    logic [PW-1:0]   fs_rd;
    logic [PW:0]     fs_top;

    logic            tm_ne;
    logic [PW-1:0]   tm_head, tm_tail;
    assign tm_ne   = tm_rd[2*PW];
    assign tm_head = tm_rd[2*PW-1:PW];
    assign tm_tail = tm_rd[PW-1:0];

    logic [TW-1:0]   e_team;
    logic [PW-1:0]   e_slot;
    logic            full;
    assign e_team = r_rng ? map_rd : '0;
    assign e_slot = (r_free_cnt != '0) ? fs_rd : r_fresh[PW-1:0];
    assign full   = (r_free_cnt == '0) && (r_fresh == (PW+1)'(POOL_SIZE));
    assign fs_top = r_free_cnt - 1'b1;

    always_comb begin
        map_we    = 1'b0;
        map_waddr = in_elem_x[EW-1:0];
        map_wdata = TW'(in_team);
        tm_we     = 1'b0;
        tm_waddr  = r_t;
        tm_wdata  = tm_rd;
        tm_raddr  = e_team;
        tm_re     = 1'b0;
        pe_we     = 1'b0;
        pn_we     = 1'b0;
        ord_we    = 1'b0;
        fs_we     = 1'b0;
        map_re    = 1'b0;
        ord_re    = 1'b0;
        fs_re     = 1'b0;
        pool_re   = 1'b0;
        unique case (r_state)
            tgq_pkg::S_IDLE: begin
                map_re = accept;
                ord_re = accept;
                fs_re  = accept;
                map_we = accept && (s_axis_tuser == tgq_pkg::K_ASSIGN)
                         && (32'(in_elem) < 32'(ELEMENT_IDS))
                         && (32'(in_team) < 32'(TEAMS));
            end
            tgq_pkg::S_E1: begin
                tm_re = !full;
                pe_we = !full;
            end
            tgq_pkg::S_E2: begin
                tm_we = 1'b1;
                if (tm_ne) begin
                    tm_wdata = {1'b1, tm_head, r_slot};
                    pn_we    = 1'b1;
                end else begin
                    tm_wdata = {1'b1, r_slot, r_slot};
                    ord_we   = (32'(r_ocnt) < 32'(TEAMS));
                end
            end
            tgq_pkg::S_D1: begin
                tm_raddr = ord_rd;
                tm_re    = 1'b1;
            end
            tgq_pkg::S_D2: begin
                pool_re = 1'b1;
                fs_we   = (32'(r_free_cnt) < 32'(POOL_SIZE));
            end
            tgq_pkg::S_D3: begin
                tm_we = 1'b1;
                if (r_slot == tm_tail) begin
                    tm_wdata = {1'b0, tm_head, tm_tail};
                end else begin
                    tm_wdata = {1'b1, pn_rd, tm_tail};
                end
            end
            tgq_pkg::S_CLR: begin
                map_waddr = EW'(r_clr);
                map_wdata = '0;
                map_we    = (32'(r_clr) < 32'(ELEMENT_IDS));
                tm_waddr  = TW'(r_clr);
                tm_wdata  = '0;
                tm_we     = (32'(r_clr) < 32'(TEAMS));
            end
            tgq_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    tgq_ram #(.WIDTH(TW), .DEPTH(ELEMENT_IDS)) u_map (
        .i_clk(i_clk), .i_we(map_we), .i_waddr(map_waddr), .i_wdata(map_wdata),
        .i_re(map_re), .i_raddr(in_elem_x[EW-1:0]), .o_rdata(map_rd)
    );

    tgq_ram #(.WIDTH(TW), .DEPTH(TEAMS)) u_order (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(r_ot), .i_wdata(r_t),
        .i_re(ord_re), .i_raddr(r_oh), .o_rdata(ord_rd)
    );

    tgq_ram #(.WIDTH(TMW), .DEPTH(TEAMS)) u_team (
        .i_clk(i_clk), .i_we(tm_we), .i_waddr(tm_waddr), .i_wdata(tm_wdata),
        .i_re(tm_re), .i_raddr(tm_raddr), .o_rdata(tm_rd)
    );

    tgq_ram #(.WIDTH(12), .DEPTH(POOL_SIZE)) u_pool_elem (
        .i_clk(i_clk), .i_we(pe_we), .i_waddr(e_slot), .i_wdata(r_elem),
        .i_re(pool_re), .i_raddr(tm_head), .o_rdata(pe_rd)
    );

    tgq_ram #(.WIDTH(PW), .DEPTH(POOL_SIZE)) u_pool_next (
        .i_clk(i_clk), .i_we(pn_we), .i_waddr(tm_tail), .i_wdata(r_slot),
        .i_re(pool_re), .i_raddr(tm_head), .o_rdata(pn_rd)
    );

    tgq_ram #(.WIDTH(PW), .DEPTH(POOL_SIZE)) u_free (
        .i_clk(i_clk), .i_we(fs_we), .i_waddr(r_free_cnt[PW-1:0]), .i_wdata(tm_head),
        .i_re(fs_re), .i_raddr(fs_top[PW-1:0]), .o_rdata(fs_rd)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tgq_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (s_axis_tuser)
                        tgq_pkg::K_ASSIGN:  n_state = tgq_pkg::S_DONE;
                        tgq_pkg::K_ENQUEUE: n_state = tgq_pkg::S_E1;
                        tgq_pkg::K_DEQUEUE: n_state = (r_ocnt == '0) ? tgq_pkg::S_DONE
                                                                     : tgq_pkg::S_D1;
                        tgq_pkg::K_CLEAR:   n_state = tgq_pkg::S_CLR;
                        default:            n_state = tgq_pkg::S_DONE;
                    endcase
                end
            end
            tgq_pkg::S_E1:   n_state = full ? tgq_pkg::S_DONE : tgq_pkg::S_E2;
            tgq_pkg::S_E2:   n_state = tgq_pkg::S_DONE;
            tgq_pkg::S_D1:   n_state = tgq_pkg::S_D2;
            tgq_pkg::S_D2:   n_state = tgq_pkg::S_D3;
            tgq_pkg::S_D3:   n_state = tgq_pkg::S_DONE;
            tgq_pkg::S_CLR: begin
                if (32'(r_clr) == CLRN - 1) begin
                    n_state = r_reply ? tgq_pkg::S_DONE : tgq_pkg::S_IDLE;
                end
            end
            tgq_pkg::S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = tgq_pkg::S_IDLE;
                end
            end
            default: n_state = tgq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tgq_pkg::S_CLR;
            r_reply     <= 1'b0;
            r_clr       <= '0;
            r_oh        <= '0;
            r_ot        <= '0;
            r_ocnt      <= '0;
            r_free_cnt  <= '0;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == tgq_pkg::S_DONE) && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                tgq_pkg::S_IDLE: begin
                    if (accept) begin
                        r_elem     <= in_elem;
                        r_rng      <= (32'(in_elem) < 32'(ELEMENT_IDS));
                        r_res_eout <= '0;
                        if (s_axis_tuser == tgq_pkg::K_DEQUEUE && r_ocnt == '0) begin
                            r_res_st <= tgq_pkg::ST_EMPTY;
                        end else begin
                            r_res_st <= tgq_pkg::ST_OK;
                        end
                        if (s_axis_tuser == tgq_pkg::K_CLEAR) begin
                            r_clr      <= '0;
                            r_reply    <= 1'b1;
                            r_oh       <= '0;
                            r_ot       <= '0;
                            r_ocnt     <= '0;
                            r_free_cnt <= '0;
                            r_fresh    <= '0;
                        end
                    end
                end
                tgq_pkg::S_E1: begin
                    r_t <= e_team;
                    if (full) begin
                        r_res_st <= tgq_pkg::ST_FULL;
                    end else begin
                        r_slot <= e_slot;
                        if (r_free_cnt != '0) begin
                            r_free_cnt <= r_free_cnt - 1'b1;
                        end else begin
                            r_fresh <= r_fresh + 1'b1;
                        end
                    end
                end
                tgq_pkg::S_E2: begin
                    if (ord_we) begin
                        r_ot   <= (r_ot == TW'(TEAMS - 1)) ? '0 : r_ot + 1'b1;
                        r_ocnt <= r_ocnt + 1'b1;
                    end
                end
                tgq_pkg::S_D1: begin
                    r_t <= ord_rd;
                end
                tgq_pkg::S_D2: begin
                    r_slot <= tm_head;
                    if (fs_we) begin
                        r_free_cnt <= r_free_cnt + 1'b1;
                    end
                end
                tgq_pkg::S_D3: begin
                    r_res_st   <= tgq_pkg::ST_DEQ;
                    r_res_eout <= pe_rd;
                    if (r_slot == tm_tail) begin
                        r_oh   <= (r_oh == TW'(TEAMS - 1)) ? '0 : r_oh + 1'b1;
                        r_ocnt <= r_ocnt - 1'b1;
                    end
                end
                tgq_pkg::S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                end
                tgq_pkg::S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_status <= r_res_st;
                        r_eout   <= r_res_eout;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_eout};
    assign m_axis_tuser  = r_status;

    `TGQ_ASSERT_ALWAYS(a_free_bound, r_free_cnt <= r_fresh)
    `TGQ_ASSERT_ALWAYS(a_order_bound, 32'(r_ocnt) <= TEAMS)
    `TGQ_ASSERT_NEXT(a_done_holds, (r_state == tgq_pkg::S_DONE) && r_out_valid
                     && !m_axis_tready, r_state == tgq_pkg::S_DONE)

endmodule

/* rtl/tgq_ram.sv */
// ----------------------------------------------------------------------------
// tgq_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tgq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
